// ===== rtl/core/rtc_tw_pkg.sv =====
// Shared types, codes and helper functions for the three-wire RTC time transfer block.
`timescale 1ns / 1ps
package rtc_tw_pkg;

   // Number of time registers moved by a get or a set
   localparam int TIME_REGISTERS = 7;
   localparam int WEEKDAY_IDX    = 3;

   // Request codes
   localparam logic [1:0] REQ_TICK = 2'd0;
   localparam logic [1:0] REQ_SET  = 2'd1;
   localparam logic [1:0] REQ_GET  = 2'd2;

   // Data pin drive codes
   localparam logic [1:0] DRIVE_RELEASE = 2'd0;
   localparam logic [1:0] DRIVE_LOW     = 2'd1;
   localparam logic [1:0] DRIVE_HIGH    = 2'd2;

   // Command and data bytes
   localparam logic [7:0] WP_ADDR    = 8'h8E;
   localparam logic [7:0] SEC_ADDR   = 8'h80;
   localparam logic [7:0] WP_OFF     = 8'h00;
   localparam logic [7:0] WP_ON      = 8'h80;
   localparam logic [7:0] HALT_VALUE = 8'h80;
   localparam logic [7:0] YEAR_LIMIT = 8'h99;

   // Frame counts and bit count
   localparam logic [3:0] SET_FRAMES    = 4'd10;
   localparam logic [3:0] GET_FRAMES    = 4'd7;
   localparam logic [3:0] BITS_PER_BYTE = 4'd8;
   localparam logic [3:0] LAST_BIT      = 4'd7;

   localparam logic [7:0] HALF_BIT_RESET = 8'd4;

   // Per-register masks applied before decoding (year, month, day, weekday, hour, min, sec)
   localparam logic [TIME_REGISTERS-1:0][7:0] DEC_MASK =
      {8'h7f, 8'h7f, 8'h3f, 8'h0f, 8'h3f, 8'h1f, 8'hff};

   // Decoded time after reset
   localparam logic [TIME_REGISTERS-1:0][6:0] DEC_RESET =
      {7'd47, 7'd59, 7'd23, 7'd7, 7'd17, 7'd7, 7'd24};

   // Sequencer phases
   typedef enum logic [7:0] {
      PH_IDLE      = 8'b0000_0001,
      PH_ADDR_LOW  = 8'b0000_0010,
      PH_ADDR_HIGH = 8'b0000_0100,
      PH_DATA_LOW  = 8'b0000_1000,
      PH_DATA_HIGH = 8'b0001_0000,
      PH_RD_LOW    = 8'b0010_0000,
      PH_RD_HIGH   = 8'b0100_0000,
      PH_GAP       = 8'b1000_0000
   } phase_type;

   // One result item
   typedef struct packed {
      logic       chip_enable;
      logic       serial_clock;
      logic [1:0] data_drive;
      logic       done_res;
      logic       present;
      logic [6:0] year_out;
      logic [4:0] month_out;
      logic [5:0] day_out;
      logic [3:0] weekday_out;
      logic [5:0] hour_out;
      logic [6:0] minute_out;
      logic [6:0] second_out;
   } rsp_type;

   // Register address of a time register
   function automatic logic [7:0] reg_addr(input logic [2:0] idx);
      logic [7:0] addr;
      case (idx)
         3'd0:    addr = 8'h8C;
         3'd1:    addr = 8'h88;
         3'd2:    addr = 8'h86;
         3'd3:    addr = 8'h8A;
         3'd4:    addr = 8'h84;
         3'd5:    addr = 8'h82;
         3'd6:    addr = 8'h80;
         default: addr = 8'h8C;
      endcase
      return addr;
   endfunction

   // Binary to packed BCD, divide by ten through a reciprocal multiply
   function automatic logic [7:0] to_bcd(input logic [6:0] v);
      logic [14:0] prod;
      logic [3:0]  tens;
      logic [6:0]  tens_x10;
      logic [6:0]  units;
      prod     = 15'(v) * 15'd205;
      tens     = prod[14:11];
      tens_x10 = 7'({tens, 3'b000}) + 7'({tens, 1'b0});
      units    = v - tens_x10;
      return {tens, units[3:0]};
   endfunction

   // Packed BCD to binary, both nibbles taken as they are
   function automatic logic [7:0] bcd_decode(input logic [7:0] b);
      logic [7:0] hi;
      hi = {4'd0, b[7:4]};
      return (hi << 3) + (hi << 1) + {4'd0, b[3:0]};
   endfunction

endpackage

// ===== rtl/core/rtc_tw_seq.sv =====
// Frame sequencer: pin timing, byte shifting, BCD encode on set and decode on get.
`timescale 1ns / 1ps
module rtc_tw_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [7:0]            csr_wr_data,
   input  logic                  accept,
   input  logic [1:0]            req_type,
   input  logic                  req_data_pin_in,
   input  logic [6:0]            req_year_in,
   input  logic [3:0]            req_month_in,
   input  logic [4:0]            req_day_in,
   input  logic [2:0]            req_weekday_in,
   input  logic [4:0]            req_hour_in,
   input  logic [5:0]            req_minute_in,
   input  logic [5:0]            req_second_in,
   output rtc_tw_pkg::rsp_type   result
);

   localparam int NREG = rtc_tw_pkg::TIME_REGISTERS;

   rtc_tw_pkg::phase_type phase_ff, phase_in;
   logic [3:0]  reg_idx_ff, reg_idx_in;
   logic [3:0]  bit_idx_ff, bit_idx_in;
   logic [7:0]  delay_ff, delay_in;
   logic [7:0]  shift_ff, shift_in;
   logic [NREG-1:0][7:0] pend_ff, pend_in;
   logic [NREG-1:0][6:0] dec_ff, dec_in;
   logic        present_ff, present_in;
   logic        set_mode_ff, set_mode_in;
   logic        ce_ff, ce_in;
   logic        clk_ff, clk_in;
   logic [1:0]  drive_ff, drive_in;
   logic [7:0]  half_bit_ff;

   logic [7:0]  half_eff;
   logic [7:0]  delay_inc;
   logic        half_done;
   logic [3:0]  val_idx_wide;
   logic [2:0]  val_idx;
   logic [7:0]  frame_value;
   logic [3:0]  next_reg_idx;
   logic [3:0]  frames_total;
   logic [7:0]  read_byte;
   logic        start_frame;
   logic        end_frame;
   logic        put_bit;
   logic        done;

   // Hold the half-bit period register
   always_ff @(posedge clock) begin
      if (reset) begin
         half_bit_ff <= rtc_tw_pkg::HALF_BIT_RESET;
      end else if (csr_wr_en) begin
         half_bit_ff <= csr_wr_data;
      end
   end

   // Half period timer, a period of zero acts as one
   assign half_eff  = (half_bit_ff == 8'd0) ? 8'd1 : half_bit_ff;
   assign delay_inc = delay_ff + 8'd1;
   assign half_done = (delay_inc >= half_eff);

   // Data byte of the current set frame
   assign val_idx_wide = reg_idx_ff - 4'd2;
   assign val_idx      = val_idx_wide[2:0];
   always_comb begin
      if (reg_idx_ff == 4'd0) begin
         frame_value = rtc_tw_pkg::WP_OFF;
      end else if (reg_idx_ff == 4'd1) begin
         frame_value = rtc_tw_pkg::HALT_VALUE;
      end else if (reg_idx_ff >= rtc_tw_pkg::SET_FRAMES - 4'd1) begin
         frame_value = rtc_tw_pkg::WP_ON;
      end else begin
         frame_value = pend_ff[val_idx];
      end
   end

   // Received byte with the sampled pin merged in
   always_comb begin
      read_byte = shift_ff;
      read_byte[bit_idx_ff[2:0]] = shift_ff[bit_idx_ff[2:0]] | req_data_pin_in;
   end

   assign next_reg_idx = reg_idx_ff + 4'd1;
   assign frames_total = set_mode_ff ? rtc_tw_pkg::SET_FRAMES : rtc_tw_pkg::GET_FRAMES;

   // Next state for one item
   always_comb begin
      logic [7:0] dec_byte;
      logic [2:0] addr_idx;
      logic [3:0] addr_idx_wide;
      phase_in    = phase_ff;
      reg_idx_in  = reg_idx_ff;
      bit_idx_in  = bit_idx_ff;
      delay_in    = delay_ff;
      shift_in    = shift_ff;
      pend_in     = pend_ff;
      dec_in      = dec_ff;
      present_in  = present_ff;
      set_mode_in = set_mode_ff;
      ce_in       = ce_ff;
      clk_in      = clk_ff;
      drive_in    = drive_ff;
      start_frame = 1'b0;
      end_frame   = 1'b0;
      put_bit     = 1'b0;
      done        = 1'b0;
      dec_byte    = 8'd0;
      addr_idx    = 3'd0;
      addr_idx_wide = 4'd0;

      if (phase_ff == rtc_tw_pkg::PH_IDLE) begin
         // Start a sequence on a set or get request
         if (req_type == rtc_tw_pkg::REQ_SET || req_type == rtc_tw_pkg::REQ_GET) begin
            set_mode_in = (req_type == rtc_tw_pkg::REQ_SET);
            reg_idx_in  = 4'd0;
            start_frame = 1'b1;
            if (req_type == rtc_tw_pkg::REQ_SET) begin
               pend_in[0] = rtc_tw_pkg::to_bcd(req_year_in);
               pend_in[1] = rtc_tw_pkg::to_bcd({3'd0, req_month_in});
               pend_in[2] = rtc_tw_pkg::to_bcd({2'd0, req_day_in});
               pend_in[3] = rtc_tw_pkg::to_bcd({4'd0, req_weekday_in});
               pend_in[4] = rtc_tw_pkg::to_bcd({2'd0, req_hour_in});
               pend_in[5] = rtc_tw_pkg::to_bcd({1'b0, req_minute_in});
               pend_in[6] = rtc_tw_pkg::to_bcd({1'b0, req_second_in});
            end
         end
      end else if (req_type == rtc_tw_pkg::REQ_TICK) begin
         // Advance the running sequence by one tick
         case (phase_ff)
            rtc_tw_pkg::PH_ADDR_LOW, rtc_tw_pkg::PH_DATA_LOW: begin
               delay_in = half_done ? 8'd0 : delay_inc;
               if (half_done) begin
                  clk_in   = 1'b1;
                  phase_in = (phase_ff == rtc_tw_pkg::PH_ADDR_LOW) ?
                             rtc_tw_pkg::PH_ADDR_HIGH : rtc_tw_pkg::PH_DATA_HIGH;
               end
            end
            rtc_tw_pkg::PH_ADDR_HIGH, rtc_tw_pkg::PH_DATA_HIGH: begin
               delay_in = half_done ? 8'd0 : delay_inc;
               if (half_done) begin
                  clk_in     = 1'b0;
                  bit_idx_in = bit_idx_ff + 4'd1;
                  if (bit_idx_in < rtc_tw_pkg::BITS_PER_BYTE) begin
                     put_bit  = 1'b1;
                     phase_in = (phase_ff == rtc_tw_pkg::PH_ADDR_HIGH) ?
                                rtc_tw_pkg::PH_ADDR_LOW : rtc_tw_pkg::PH_DATA_LOW;
                  end else begin
                     bit_idx_in = 4'd0;
                     if (phase_ff == rtc_tw_pkg::PH_DATA_HIGH) begin
                        end_frame = 1'b1;
                     end else if (set_mode_ff) begin
                        shift_in = frame_value;
                        put_bit  = 1'b1;
                        phase_in = rtc_tw_pkg::PH_DATA_LOW;
                     end else begin
                        shift_in = 8'd0;
                        drive_in = rtc_tw_pkg::DRIVE_RELEASE;
                        phase_in = rtc_tw_pkg::PH_RD_LOW;
                     end
                  end
               end
            end
            rtc_tw_pkg::PH_RD_LOW: begin
               delay_in = half_done ? 8'd0 : delay_inc;
               if (half_done) begin
                  shift_in = read_byte;
                  if (bit_idx_ff < rtc_tw_pkg::LAST_BIT) begin
                     clk_in   = 1'b1;
                     phase_in = rtc_tw_pkg::PH_RD_HIGH;
                  end else begin
                     if (reg_idx_ff < rtc_tw_pkg::GET_FRAMES) begin
                        pend_in[reg_idx_ff[2:0]] = read_byte;
                     end
                     end_frame = 1'b1;
                  end
               end
            end
            rtc_tw_pkg::PH_RD_HIGH: begin
               delay_in = half_done ? 8'd0 : delay_inc;
               if (half_done) begin
                  clk_in     = 1'b0;
                  bit_idx_in = bit_idx_ff + 4'd1;
                  phase_in   = rtc_tw_pkg::PH_RD_LOW;
               end
            end
            rtc_tw_pkg::PH_GAP: begin
               start_frame = 1'b1;
            end
            default: begin
               phase_in = rtc_tw_pkg::PH_IDLE;
            end
         endcase
      end

      // Close a frame: gap before the next one, or finish the sequence
      if (end_frame) begin
         ce_in  = 1'b0;
         clk_in = 1'b0;
         if (next_reg_idx < frames_total) begin
            reg_idx_in = next_reg_idx;
            phase_in   = rtc_tw_pkg::PH_GAP;
         end else begin
            reg_idx_in = 4'd0;
            phase_in   = rtc_tw_pkg::PH_IDLE;
            done       = 1'b1;
            if (set_mode_ff) begin
               drive_in = rtc_tw_pkg::DRIVE_HIGH;
            end else if (pend_in[0] > rtc_tw_pkg::YEAR_LIMIT) begin
               // Missing chip: keep the old time, leave the pin released
               present_in = 1'b0;
            end else begin
               for (int k = 0; k < NREG; k++) begin
                  dec_byte = pend_in[k] & rtc_tw_pkg::DEC_MASK[k];
                  if (k != rtc_tw_pkg::WEEKDAY_IDX) begin
                     dec_byte = rtc_tw_pkg::bcd_decode(dec_byte);
                  end
                  dec_in[k] = dec_byte[6:0];
               end
               present_in = 1'b1;
               drive_in   = rtc_tw_pkg::DRIVE_HIGH;
            end
         end
      end

      // Open a frame with its command byte
      if (start_frame) begin
         ce_in      = 1'b1;
         clk_in     = 1'b0;
         bit_idx_in = 4'd0;
         delay_in   = 8'd0;
         put_bit    = 1'b1;
         phase_in   = rtc_tw_pkg::PH_ADDR_LOW;
         if (!set_mode_in) begin
            addr_idx = (reg_idx_in < rtc_tw_pkg::GET_FRAMES) ? reg_idx_in[2:0] : 3'd0;
            shift_in = rtc_tw_pkg::reg_addr(addr_idx) | 8'h01;
         end else if (reg_idx_in == 4'd0 ||
                      reg_idx_in >= rtc_tw_pkg::SET_FRAMES - 4'd1) begin
            shift_in = rtc_tw_pkg::WP_ADDR;
         end else if (reg_idx_in == 4'd1) begin
            shift_in = rtc_tw_pkg::SEC_ADDR;
         end else begin
            addr_idx_wide = reg_idx_in - 4'd2;
            shift_in = rtc_tw_pkg::reg_addr(addr_idx_wide[2:0]);
         end
      end

      // Drive the current bit, low bit first
      if (put_bit) begin
         drive_in = shift_in[bit_idx_in[2:0]] ? rtc_tw_pkg::DRIVE_HIGH : rtc_tw_pkg::DRIVE_LOW;
      end
   end

   // Update state on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= rtc_tw_pkg::PH_IDLE;
         reg_idx_ff  <= 4'd0;
         bit_idx_ff  <= 4'd0;
         delay_ff    <= 8'd0;
         shift_ff    <= 8'd0;
         pend_ff     <= '0;
         dec_ff      <= rtc_tw_pkg::DEC_RESET;
         present_ff  <= 1'b0;
         set_mode_ff <= 1'b0;
         ce_ff       <= 1'b0;
         clk_ff      <= 1'b0;
         drive_ff    <= rtc_tw_pkg::DRIVE_HIGH;
      end else if (accept) begin
         phase_ff    <= phase_in;
         reg_idx_ff  <= reg_idx_in;
         bit_idx_ff  <= bit_idx_in;
         delay_ff    <= delay_in;
         shift_ff    <= shift_in;
         pend_ff     <= pend_in;
         dec_ff      <= dec_in;
         present_ff  <= present_in;
         set_mode_ff <= set_mode_in;
         ce_ff       <= ce_in;
         clk_ff      <= clk_in;
         drive_ff    <= drive_in;
      end
   end

   // Result item for this tick
   always_comb begin
      result.chip_enable  = ce_in;
      result.serial_clock = clk_in;
      result.data_drive   = drive_in;
      result.done_res     = done;
      result.present      = present_in;
      result.year_out     = dec_in[0];
      result.month_out    = dec_in[1][4:0];
      result.day_out      = dec_in[2][5:0];
      result.weekday_out  = dec_in[3][3:0];
      result.hour_out     = dec_in[4][5:0];
      result.minute_out   = dec_in[5];
      result.second_out   = dec_in[6];
   end

endmodule

// ===== rtl/core/rtc_tw_outq.sv =====
// Two-entry result queue that decouples the result channel from the request channel.
`timescale 1ns / 1ps
module rtc_tw_outq (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  rtc_tw_pkg::rsp_type push_data,
   output logic                full,
   output logic                out_valid,
   input  logic                out_stall,
   output rtc_tw_pkg::rsp_type out_data
);

   rtc_tw_pkg::rsp_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign full      = (count_ff == 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign pop       = out_valid && !out_stall;
   assign out_data  = entry_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed item
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/core/rtc_three_wire_time_transfer.sv =====
// Top level of the three-wire RTC time transfer master.
// A result item is written into the result queue when its request item is accepted.
// One request item is accepted per cycle while the two-entry result queue is not full.
// req_stall rises only when the result queue holds two items.
// Reset (synchronous, active high): sequencer idle, pins low with data driven high,
// half-bit period 4, decoded time at its default, result queue empty.
`timescale 1ns / 1ps
module rtc_three_wire_time_transfer (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_type,
   input  logic       req_data_pin_in,
   input  logic [6:0] req_year_in,
   input  logic [3:0] req_month_in,
   input  logic [4:0] req_day_in,
   input  logic [2:0] req_weekday_in,
   input  logic [4:0] req_hour_in,
   input  logic [5:0] req_minute_in,
   input  logic [5:0] req_second_in,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_chip_enable,
   output logic       rsp_serial_clock,
   output logic [1:0] rsp_data_drive,
   output logic       rsp_done_res,
   output logic       rsp_present,
   output logic [6:0] rsp_year_out,
   output logic [4:0] rsp_month_out,
   output logic [5:0] rsp_day_out,
   output logic [3:0] rsp_weekday_out,
   output logic [5:0] rsp_hour_out,
   output logic [6:0] rsp_minute_out,
   output logic [6:0] rsp_second_out
);

   rtc_tw_pkg::rsp_type seq_result;
   rtc_tw_pkg::rsp_type out_item;
   logic                accept;
   logic                queue_full;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   rtc_tw_seq u_seq (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .accept          (accept),
      .req_type        (req_type),
      .req_data_pin_in (req_data_pin_in),
      .req_year_in     (req_year_in),
      .req_month_in    (req_month_in),
      .req_day_in      (req_day_in),
      .req_weekday_in  (req_weekday_in),
      .req_hour_in     (req_hour_in),
      .req_minute_in   (req_minute_in),
      .req_second_in   (req_second_in),
      .result          (seq_result)
   );

   rtc_tw_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (seq_result),
      .full      (queue_full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (out_item)
   );

   // Unpack the result item onto the ports
   assign rsp_chip_enable  = out_item.chip_enable;
   assign rsp_serial_clock = out_item.serial_clock;
   assign rsp_data_drive   = out_item.data_drive;
   assign rsp_done_res     = out_item.done_res;
   assign rsp_present      = out_item.present;
   assign rsp_year_out     = out_item.year_out;
   assign rsp_month_out    = out_item.month_out;
   assign rsp_day_out      = out_item.day_out;
   assign rsp_weekday_out  = out_item.weekday_out;
   assign rsp_hour_out     = out_item.hour_out;
   assign rsp_minute_out   = out_item.minute_out;
   assign rsp_second_out   = out_item.second_out;

   // An accepted item always leaves a result waiting in the next cycle
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("accepted item left no result");

   // A finished sequence closes the frame
   a_done_frame_closed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_done_res) |-> (!rsp_chip_enable && !rsp_serial_clock))
      else $error("sequence finished with frame still open");

   // A finished sequence never leaves the data pin driven low
   a_done_pin_state: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_done_res) |-> (rsp_data_drive != rtc_tw_pkg::DRIVE_LOW))
      else $error("data pin driven low at end of sequence");

endmodule

// ===== tb/tb_rtc_three_wire_time_transfer.sv =====
// Self-checking testbench for the three-wire RTC time transfer master, with a built-in predictor.
`timescale 1ns / 1ps
module tb_rtc_three_wire_time_transfer;
   import rtc_tw_pkg::*;

   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 20;
   localparam int MAX_REPORTS = 200;

   // Command bytes of the time registers: year, month, date, weekday, hour, minute, second
   localparam logic [0:6][7:0] TIME_CMD =
      {8'h8C, 8'h88, 8'h86, 8'h8A, 8'h84, 8'h82, 8'h80};
   localparam logic [0:6][7:0] FIELD_MASK =
      {8'hff, 8'h1f, 8'h3f, 8'h0f, 8'h3f, 8'h7f, 8'h7f};
   localparam logic [0:6][6:0] TIME_AT_RESET =
      {7'd24, 7'd7, 7'd17, 7'd7, 7'd23, 7'd59, 7'd47};

   // Outputs right after reset, and right after a set opens its first frame
   localparam rsp_type AT_RESET = {1'b0, 1'b0, DRIVE_HIGH, 1'b0, 1'b0,
      7'd24, 5'd7, 6'd17, 4'd7, 6'd23, 7'd59, 7'd47};
   localparam rsp_type SET_OPEN = {1'b1, 1'b0, DRIVE_LOW, 1'b0, 1'b0,
      7'd24, 5'd7, 6'd17, 4'd7, 6'd23, 7'd59, 7'd47};

   typedef struct packed {
      logic [1:0] kind;
      logic       pin;
      logic [6:0] year;
      logic [3:0] month;
      logic [4:0] day;
      logic [2:0] wday;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
   } req_item_t;

   typedef struct packed {
      req_item_t stim;
      logic      typed;
      rsp_type   want;
   } plan_row_t;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_wr_en = 1'b0;
   logic [7:0] csr_wr_data = 8'd0;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_type = REQ_TICK;
   logic       req_data_pin_in = 1'b0;
   logic [6:0] req_year_in = 7'd0;
   logic [3:0] req_month_in = 4'd0;
   logic [4:0] req_day_in = 5'd0;
   logic [2:0] req_weekday_in = 3'd0;
   logic [4:0] req_hour_in = 5'd0;
   logic [5:0] req_minute_in = 6'd0;
   logic [5:0] req_second_in = 6'd0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_chip_enable;
   logic       rsp_serial_clock;
   logic [1:0] rsp_data_drive;
   logic       rsp_done_res;
   logic       rsp_present;
   logic [6:0] rsp_year_out;
   logic [4:0] rsp_month_out;
   logic [5:0] rsp_day_out;
   logic [3:0] rsp_weekday_out;
   logic [5:0] rsp_hour_out;
   logic [6:0] rsp_minute_out;
   logic [6:0] rsp_second_out;

   rtc_three_wire_time_transfer dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_data_pin_in  (req_data_pin_in),
      .req_year_in      (req_year_in),
      .req_month_in     (req_month_in),
      .req_day_in       (req_day_in),
      .req_weekday_in   (req_weekday_in),
      .req_hour_in      (req_hour_in),
      .req_minute_in    (req_minute_in),
      .req_second_in    (req_second_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_chip_enable  (rsp_chip_enable),
      .rsp_serial_clock (rsp_serial_clock),
      .rsp_data_drive   (rsp_data_drive),
      .rsp_done_res     (rsp_done_res),
      .rsp_present      (rsp_present),
      .rsp_year_out     (rsp_year_out),
      .rsp_month_out    (rsp_month_out),
      .rsp_day_out      (rsp_day_out),
      .rsp_weekday_out  (rsp_weekday_out),
      .rsp_hour_out     (rsp_hour_out),
      .rsp_minute_out   (rsp_minute_out),
      .rsp_second_out   (rsp_second_out)
   );

   always #5 clock = ~clock;

   // Predictor state: sequencer, shift path, staged bytes, held time and pin levels
   phase_type        seq_phase = PH_IDLE;
   logic [3:0]       frame_no = 4'd0;
   logic [3:0]       bit_no = 4'd0;
   logic [7:0]       half_count = 8'd0;
   logic [7:0]       shift_reg = 8'd0;
   logic [7:0]       half_ticks = HALF_BIT_RESET;
   logic [0:6][7:0]  staged_bytes = '0;
   logic [0:6][6:0]  held_time = TIME_AT_RESET;
   logic             chip_seen = 1'b0;
   logic             writing = 1'b0;
   logic             pin_ce = 1'b0;
   logic             pin_clk = 1'b0;
   logic [1:0]       pin_drv = DRIVE_HIGH;

   // Register image that the emulated chip returns on a get
   logic [0:6][7:0]  chip_regs = '0;

   rsp_type outputs_due_q [$];
   plan_row_t plan [$];
   int fault_count = 0;
   int send_run = 0;
   int take_run = 0;
   int take_left = 0;
   int quiet_cycles = 0;

   function automatic logic [7:0] bcd_of(input int unsigned v);
      return 8'(((v / 10) << 4) | (v % 10));
   endfunction

   // Present the current bit of the shift register on the data pin
   function automatic void drive_bit();
      pin_drv = shift_reg[bit_no[2:0]] ? DRIVE_HIGH : DRIVE_LOW;
   endfunction

   // Count one tick of a clock half; true when the half is over
   function automatic bit half_done();
      logic [7:0] lim;
      lim = (half_ticks == 8'd0) ? 8'd1 : half_ticks;
      half_count = half_count + 8'd1;
      if (half_count >= lim) begin
         half_count = 8'd0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Raise chip enable and load the command byte of the current frame
   function automatic void open_frame();
      pin_ce = 1'b1;
      pin_clk = 1'b0;
      if (!writing)
         shift_reg = TIME_CMD[frame_no[2:0]] | 8'h01;
      else if (frame_no == 4'd0 || frame_no >= SET_FRAMES - 4'd1)
         shift_reg = WP_ADDR;
      else if (frame_no == 4'd1)
         shift_reg = SEC_ADDR;
      else
         shift_reg = TIME_CMD[3'(frame_no - 4'd2)];
      bit_no = 4'd0;
      half_count = 8'd0;
      drive_bit();
      seq_phase = PH_ADDR_LOW;
   endfunction

   // Drop chip enable, advance the frame, and finish the sequence after the last one
   function automatic bit close_frame();
      logic [3:0] total;
      logic [7:0] b;
      total = writing ? SET_FRAMES : GET_FRAMES;
      pin_ce = 1'b0;
      pin_clk = 1'b0;
      frame_no = frame_no + 4'd1;
      if (frame_no < total) begin
         seq_phase = PH_GAP;
         return 1'b0;
      end
      seq_phase = PH_IDLE;
      frame_no = 4'd0;
      if (writing) begin
         pin_drv = DRIVE_HIGH;
      end else if (staged_bytes[0] > YEAR_LIMIT) begin
         // no chip answered: keep the old time, leave the pin released
         chip_seen = 1'b0;
      end else begin
         for (int k = 0; k < TIME_REGISTERS; k++) begin
            b = staged_bytes[k] & FIELD_MASK[k];
            if (k != WEEKDAY_IDX)
               b = 8'(b[7:4] * 8'd10 + b[3:0]);
            held_time[k] = b[6:0];
         end
         chip_seen = 1'b1;
         pin_drv = DRIVE_HIGH;
      end
      return 1'b1;
   endfunction

   // Advance a running sequence by one tick; true on the tick it finishes
   function automatic bit seq_tick(input logic pin);
      case (seq_phase)
         PH_ADDR_LOW, PH_DATA_LOW: begin
            if (half_done()) begin
               pin_clk = 1'b1;
               seq_phase = (seq_phase == PH_ADDR_LOW) ? PH_ADDR_HIGH : PH_DATA_HIGH;
            end
         end
         PH_ADDR_HIGH, PH_DATA_HIGH: begin
            if (half_done()) begin
               pin_clk = 1'b0;
               bit_no = bit_no + 4'd1;
               if (bit_no < BITS_PER_BYTE) begin
                  drive_bit();
                  seq_phase = (seq_phase == PH_ADDR_HIGH) ? PH_ADDR_LOW : PH_DATA_LOW;
               end else begin
                  bit_no = 4'd0;
                  if (seq_phase == PH_DATA_HIGH)
                     return close_frame();
                  if (writing) begin
                     if (frame_no == 4'd0)
                        shift_reg = WP_OFF;
                     else if (frame_no == 4'd1)
                        shift_reg = HALT_VALUE;
                     else if (frame_no >= SET_FRAMES - 4'd1)
                        shift_reg = WP_ON;
                     else
                        shift_reg = staged_bytes[3'(frame_no - 4'd2)];
                     drive_bit();
                     seq_phase = PH_DATA_LOW;
                  end else begin
                     shift_reg = 8'd0;
                     pin_drv = DRIVE_RELEASE;
                     seq_phase = PH_RD_LOW;
                  end
               end
            end
         end
         PH_RD_LOW: begin
            if (half_done()) begin
               // sample at the end of the low half
               if (pin)
                  shift_reg[bit_no[2:0]] = 1'b1;
               if (bit_no < LAST_BIT) begin
                  pin_clk = 1'b1;
                  seq_phase = PH_RD_HIGH;
               end else begin
                  if (frame_no < 4'(TIME_REGISTERS))
                     staged_bytes[frame_no[2:0]] = shift_reg;
                  return close_frame();
               end
            end
         end
         PH_RD_HIGH: begin
            if (half_done()) begin
               pin_clk = 1'b0;
               bit_no = bit_no + 4'd1;
               seq_phase = PH_RD_LOW;
            end
         end
         PH_GAP: open_frame();
         default: seq_phase = PH_IDLE;
      endcase
      return 1'b0;
   endfunction

   // Predict the outputs after one accepted item
   function automatic rsp_type predict_outputs(input req_item_t it);
      rsp_type r;
      bit fin;
      fin = 1'b0;
      if (seq_phase == PH_IDLE) begin
         if (it.kind == REQ_SET || it.kind == REQ_GET) begin
            writing = (it.kind == REQ_SET);
            if (writing) begin
               staged_bytes[0] = bcd_of(it.year);
               staged_bytes[1] = bcd_of(it.month);
               staged_bytes[2] = bcd_of(it.day);
               staged_bytes[3] = bcd_of(it.wday);
               staged_bytes[4] = bcd_of(it.hour);
               staged_bytes[5] = bcd_of(it.minute);
               staged_bytes[6] = bcd_of(it.second);
            end
            frame_no = 4'd0;
            open_frame();
         end
      end else if (it.kind == REQ_TICK) begin
         fin = seq_tick(it.pin);
      end
      r.chip_enable  = pin_ce;
      r.serial_clock = pin_clk;
      r.data_drive   = pin_drv;
      r.done_res     = fin;
      r.present      = chip_seen;
      r.year_out     = held_time[0];
      r.month_out    = held_time[1][4:0];
      r.day_out      = held_time[2][5:0];
      r.weekday_out  = held_time[3][3:0];
      r.hour_out     = held_time[4][5:0];
      r.minute_out   = held_time[5];
      r.second_out   = held_time[6];
      return r;
   endfunction

   function automatic req_item_t mk_item(input logic [1:0] kind, input logic pin,
         input logic [6:0] y, input logic [3:0] mo, input logic [4:0] d,
         input logic [2:0] w, input logic [4:0] h, input logic [5:0] mi,
         input logic [5:0] s);
      return {kind, pin, y, mo, d, w, h, mi, s};
   endfunction

   // Random item of a given kind; set fields mostly in range, sometimes any bit pattern
   function automatic req_item_t rand_item(input logic [1:0] kind);
      req_item_t it;
      it.kind = kind;
      it.pin = 1'($urandom);
      if ($urandom_range(0, 9) < 7) begin
         it.year   = 7'($urandom_range(0, 99));
         it.month  = 4'($urandom_range(1, 12));
         it.day    = 5'($urandom_range(1, 31));
         it.wday   = 3'($urandom_range(1, 7));
         it.hour   = 5'($urandom_range(0, 23));
         it.minute = 6'($urandom_range(0, 59));
         it.second = 6'($urandom_range(0, 59));
      end else begin
         it.year   = 7'($urandom);
         it.month  = 4'($urandom);
         it.day    = 5'($urandom);
         it.wday   = 3'($urandom);
         it.hour   = 5'($urandom);
         it.minute = 6'($urandom);
         it.second = 6'($urandom);
      end
      return it;
   endfunction

   // Cycles to wait before the next item; now and then a run with no waits at all
   function automatic int pick_wait(inout int run);
      if (run > 0) begin
         run--;
         return 0;
      end
      if ($urandom_range(0, 24) == 0) begin
         run = $urandom_range(10, 60);
         return 0;
      end
      return $urandom_range(0, 9);
   endfunction

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         fault_count++;
         if (fault_count <= MAX_REPORTS)
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      end
   endtask

   task automatic compare_outputs(input rsp_type want, input rsp_type got);
      check_field("chip_enable", 8'(want.chip_enable), 8'(got.chip_enable));
      check_field("serial_clock", 8'(want.serial_clock), 8'(got.serial_clock));
      check_field("data_drive", 8'(want.data_drive), 8'(got.data_drive));
      check_field("done_res", 8'(want.done_res), 8'(got.done_res));
      check_field("present", 8'(want.present), 8'(got.present));
      check_field("year_out", 8'(want.year_out), 8'(got.year_out));
      check_field("month_out", 8'(want.month_out), 8'(got.month_out));
      check_field("day_out", 8'(want.day_out), 8'(got.day_out));
      check_field("weekday_out", 8'(want.weekday_out), 8'(got.weekday_out));
      check_field("hour_out", 8'(want.hour_out), 8'(got.hour_out));
      check_field("minute_out", 8'(want.minute_out), 8'(got.minute_out));
      check_field("second_out", 8'(want.second_out), 8'(got.second_out));
   endtask

   // Drive one item, hold it until accepted, then queue its expected outputs
   task automatic issue(input req_item_t it, input logic typed, input rsp_type want);
      int gap;
      rsp_type got;
      gap = pick_wait(send_run);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_type        <= it.kind;
      req_data_pin_in <= it.pin;
      req_year_in     <= it.year;
      req_month_in    <= it.month;
      req_day_in      <= it.day;
      req_weekday_in  <= it.wday;
      req_hour_in     <= it.hour;
      req_minute_in   <= it.minute;
      req_second_in   <= it.second;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      got = predict_outputs(it);
      outputs_due_q.push_back(typed ? want : got);
   endtask

   // Drain all results, then write the half-bit period
   task automatic write_half_period(input logic [7:0] ticks);
      req_valid <= 1'b0;
      while (outputs_due_q.size() != 0) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= ticks;
      @(posedge clock);
      half_ticks = ticks;
      csr_wr_en <= 1'b0;
   endtask

   // Random traffic: mostly complete set and get sequences, with ignored noise mixed in
   task automatic run_phase(input int budget);
      int taken;
      req_item_t it;
      logic [1:0] kind;
      taken = 0;
      while (taken < budget) begin
         if (seq_phase == PH_IDLE) begin
            if ($urandom_range(0, 3) == 0) begin
               // idle tick or unused code, both ignored
               it = rand_item($urandom_range(0, 1) ? REQ_TICK : REQ_UNUSED);
            end else if ($urandom_range(0, 9) < 4) begin
               it = rand_item(REQ_SET);
               taken++;
            end else begin
               it = rand_item(REQ_GET);
               taken++;
               // load the register image the chip will return
               case ($urandom_range(0, 9))
                  6, 7: begin
                     for (int k = 0; k < TIME_REGISTERS; k++)
                        chip_regs[k] = 8'($urandom);
                  end
                  8, 9: begin
                     for (int k = 0; k < TIME_REGISTERS; k++)
                        chip_regs[k] = 8'($urandom);
                     chip_regs[0] = 8'($urandom_range(8'h9A, 8'hFF));
                  end
                  default: begin
                     chip_regs[0] = bcd_of($urandom_range(0, 99));
                     chip_regs[1] = bcd_of($urandom_range(1, 12));
                     chip_regs[2] = bcd_of($urandom_range(1, 31));
                     chip_regs[3] = 8'($urandom_range(1, 7));
                     chip_regs[4] = bcd_of($urandom_range(0, 23));
                     chip_regs[5] = bcd_of($urandom_range(0, 59));
                     chip_regs[6] = bcd_of($urandom_range(0, 59));
                     // junk in the bits the block masks off, halt bit among them
                     if ($urandom_range(0, 1))
                        for (int k = 0; k < TIME_REGISTERS; k++)
                           chip_regs[k] = chip_regs[k] | (8'($urandom) & ~FIELD_MASK[k]);
                  end
               endcase
            end
         end else if ($urandom_range(0, 24) == 0) begin
            // command while busy, ignored
            case ($urandom_range(0, 2))
               0:       kind = REQ_SET;
               1:       kind = REQ_GET;
               default: kind = REQ_UNUSED;
            endcase
            it = rand_item(kind);
         end else begin
            it = rand_item(REQ_TICK);
            if (seq_phase == PH_RD_LOW)
               it.pin = chip_regs[frame_no[2:0]][bit_no[2:0]];
            taken++;
         end
         issue(it, 1'b0, AT_RESET);
      end
   endtask

   // Result side: random stall, check each accepted item against the oldest expectation
   always @(posedge clock) begin : take_results
      rsp_type got;
      if (reset) begin
         rsp_stall <= 1'b0;
         take_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_chip_enable, rsp_serial_clock, rsp_data_drive, rsp_done_res,
                   rsp_present, rsp_year_out, rsp_month_out, rsp_day_out,
                   rsp_weekday_out, rsp_hour_out, rsp_minute_out, rsp_second_out};
            if (outputs_due_q.size() == 0) begin
               fault_count++;
               if (fault_count <= MAX_REPORTS)
                  $display("%0t: result expected none got %h", $time, got);
            end else begin
               compare_outputs(outputs_due_q.pop_front(), got);
            end
            take_left = pick_wait(take_run);
         end else if (take_left != 0) begin
            take_left--;
         end
         rsp_stall <= (take_left != 0);
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   initial begin
      // directed rows: idle behavior, a set with every field at its top, busy commands
      plan.push_back({mk_item(REQ_TICK, 1'b0, 7'd0, 4'd0, 5'd0, 3'd0, 5'd0, 6'd0, 6'd0),
                      1'b1, AT_RESET});
      plan.push_back({mk_item(REQ_UNUSED, 1'b1, 7'h7f, 4'hf, 5'h1f, 3'h7, 5'h1f, 6'h3f,
                      6'h3f), 1'b1, AT_RESET});
      plan.push_back({mk_item(REQ_SET, 1'b0, 7'h7f, 4'hf, 5'h1f, 3'h7, 5'h1f, 6'h3f, 6'h3f),
                      1'b1, SET_OPEN});
      plan.push_back({mk_item(REQ_GET, 1'b1, 7'd0, 4'd0, 5'd0, 3'd0, 5'd0, 6'd0, 6'd0),
                      1'b1, SET_OPEN});
      plan.push_back({mk_item(REQ_SET, 1'b0, 7'd0, 4'd0, 5'd0, 3'd0, 5'd0, 6'd0, 6'd0),
                      1'b1, SET_OPEN});
      plan.push_back({mk_item(REQ_UNUSED, 1'b1, 7'h7f, 4'hf, 5'h1f, 3'h7, 5'h1f, 6'h3f,
                      6'h3f), 1'b1, SET_OPEN});
      for (int n = 0; n < 14; n++)
         plan.push_back({mk_item(REQ_TICK, 1'(n), 7'd0, 4'd0, 5'd0, 3'd0, 5'd0, 6'd0,
                         6'd0), 1'b0, AT_RESET});

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i])
         issue(plan[i].stim, plan[i].typed, plan[i].want);

      // random phases over several half-bit periods, zero and the maximum among them
      write_half_period(8'd1);
      run_phase(600);
      write_half_period(8'd0);
      run_phase(400);
      write_half_period(8'd255);
      run_phase(100);
      write_half_period(8'd2);
      run_phase(350);
      write_half_period(8'd1);
      run_phase(480);

      req_valid <= 1'b0;
      while (outputs_due_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/rtc_tw_pkg.sv
rtl/core/rtc_tw_seq.sv
rtl/core/rtc_tw_outq.sv
rtl/core/rtc_three_wire_time_transfer.sv
tb/tb_rtc_three_wire_time_transfer.sv
